[design/chls_pkg.sv]
package chls_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_TARGET_HUMIDITY        = 3'd0;
   localparam csr_index_type CSR_HUMIDITY_HYSTERESIS    = 3'd1;
   localparam csr_index_type CSR_TARGET_TEMPERATURE     = 3'd2;
   localparam csr_index_type CSR_TEMPERATURE_HYSTERESIS = 3'd3;
   localparam csr_index_type CSR_LIGHT_ON_MINUTE        = 3'd4;
   localparam csr_index_type CSR_LIGHT_OFF_MINUTE       = 3'd5;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_HUMIDITY    = 2'd0;
   localparam kind_type KIND_TEMPERATURE = 2'd1;
   localparam kind_type KIND_CLOCK       = 2'd2;
   localparam kind_type KIND_UNKNOWN     = 2'd3;

   typedef logic [1:0] cmd_type;

   localparam cmd_type CMD_OFF  = 2'd0;
   localparam cmd_type CMD_LOW  = 2'd1;
   localparam cmd_type CMD_HIGH = 2'd2;

   // seconds / 60 = (seconds / 4) / 15, by reciprocal multiply
   localparam logic [31:0] RECIP_15       = 32'h8888_8889;
   localparam int unsigned RECIP_15_SHIFT = 35;
   // minutes / 1440 = (minutes / 32) / 45, by reciprocal multiply
   localparam logic [21:0] RECIP_45       = 22'd2982617;
   localparam int unsigned RECIP_45_SHIFT = 27;
   localparam logic [25:0] MINUTES_PER_DAY = 26'd1440;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] sample;
      logic [30:0]        unix_seconds;
   } req_type;

   typedef struct packed {
      cmd_type humidity_command;
      cmd_type temperature_command;
      logic    light_command;
   } rsp_type;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } stage_en_type;

endpackage

[design/chls_band.sv]
module chls_band (
   input  chls_pkg::cmd_type    mode,
   input  logic signed [15:0]   reading,
   input  logic signed [15:0]   target,
   input  logic [14:0]          hysteresis,
   output chls_pkg::cmd_type    mode_next
);

   logic signed [17:0] reading_x;
   logic signed [17:0] half;
   logic signed [17:0] quarter;
   logic signed [17:0] upper;
   logic signed [17:0] lower;
   logic signed [17:0] off_upper;
   logic signed [17:0] off_lower;

   always_comb begin
      reading_x = 18'(reading);
      half      = $signed({4'd0, hysteresis[14:1]});
      quarter   = $signed({5'd0, hysteresis[14:2]});
      upper     = 18'(target) + half;
      lower     = 18'(target) - half;
      off_upper = 18'(target) + quarter;
      off_lower = 18'(target) - quarter;
      if (reading_x > upper) begin
         mode_next = chls_pkg::CMD_HIGH;
      end else if (reading_x < lower) begin
         mode_next = chls_pkg::CMD_LOW;
      end else if (reading_x >= off_lower && reading_x <= off_upper) begin
         mode_next = chls_pkg::CMD_OFF;
      end else begin
         mode_next = mode;
      end
   end

endmodule

[design/chls_minute.sv]
module chls_minute (
   input  logic                    clock,
   input  chls_pkg::stage_en_type  stage_en,
   input  logic [30:0]             unix_seconds,
   output logic [10:0]             minute
);

   logic [30:0] secs_ff;
   logic [25:0] q1_ff;
   logic [25:0] q1_hold_ff;
   logic [15:0] day_ff;

   logic [60:0] p1;
   logic [42:0] p2;
   logic [25:0] day_minutes;
   logic [25:0] remainder;

   always_comb begin
      p1          = 61'(secs_ff[30:2]) * 61'(chls_pkg::RECIP_15);
      p2          = 43'(q1_ff[25:5]) * 43'(chls_pkg::RECIP_45);
      day_minutes = 26'(day_ff) * chls_pkg::MINUTES_PER_DAY;
      remainder   = q1_hold_ff - day_minutes;
      minute      = remainder[10:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en.en1) begin
         secs_ff <= unix_seconds;
      end
      if (stage_en.en2) begin
         q1_ff <= p1[60:chls_pkg::RECIP_15_SHIFT];
      end
      if (stage_en.en3) begin
         q1_hold_ff <= q1_ff;
         day_ff     <= p2[42:chls_pkg::RECIP_45_SHIFT];
      end
   end

endmodule

[design/climate_hysteresis_light_scheduler.sv]
// Channel | Direction | Handshake               | Beat
// req_    | in        | req_valid / req_stall   | chls_pkg::req_type
// rsp_    | out       | rsp_valid / rsp_stall   | chls_pkg::rsp_type
// csr_    | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// One beat per cycle while rsp_stall is low; each beat passes every stage to rsp_.
// Depth is set by the minute-of-day pipeline: two reciprocal multiplies, one per stage.
// Bubbles collapse; req_stall rises only with every stage full and rsp_stall high.
// Reset clears the setpoints, the modes, the light and all stage valids.
// csr_ready is always high; writes go to the registers at once.
module climate_hysteresis_light_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  chls_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output chls_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  chls_pkg::csr_index_type       csr_index,
   input  logic [15:0]                   csr_data
);

   logic signed [15:0] target_humidity_ff;
   logic [14:0]        humidity_hysteresis_ff;
   logic signed [15:0] target_temperature_ff;
   logic [14:0]        temperature_hysteresis_ff;
   logic [10:0]        light_on_minute_ff;
   logic [10:0]        light_off_minute_ff;

   logic               v1_ff;
   logic               v2_ff;
   logic               v3_ff;
   logic               rsp_valid_ff;
   logic               v1_in;
   logic               v2_in;
   logic               v3_in;
   logic               rsp_valid_in;

   chls_pkg::kind_type kind1_ff;
   chls_pkg::kind_type kind2_ff;
   chls_pkg::kind_type kind3_ff;
   logic signed [15:0] sample1_ff;
   logic signed [15:0] sample2_ff;
   logic signed [15:0] sample3_ff;

   chls_pkg::rsp_type      rsp_ff;
   chls_pkg::rsp_type      rsp_in;
   chls_pkg::stage_en_type stage_en;
   logic                   out_free;
   logic                   adv4;
   logic [10:0]            minute;
   logic                   light_next;
   chls_pkg::cmd_type      humidity_next;
   chls_pkg::cmd_type      temperature_next;

   always_comb begin
      out_free    = !rsp_valid_ff || !rsp_stall;
      adv4        = v3_ff && out_free;
      stage_en.en3 = !v3_ff || adv4;
      stage_en.en2 = !v2_ff || stage_en.en3;
      stage_en.en1 = !v1_ff || stage_en.en2;
      req_stall   = !stage_en.en1;
      v1_in       = stage_en.en1 ? req_valid : v1_ff;
      v2_in       = stage_en.en2 ? v1_ff : v2_ff;
      v3_in       = stage_en.en3 ? v2_ff : v3_ff;
      rsp_valid_in = out_free ? v3_ff : rsp_valid_ff;
   end

   chls_minute u_minute (
      .clock        (clock),
      .stage_en     (stage_en),
      .unix_seconds (req_data.unix_seconds),
      .minute       (minute)
   );

   chls_band u_humidity_band (
      .mode       (rsp_ff.humidity_command),
      .reading    (sample3_ff),
      .target     (target_humidity_ff),
      .hysteresis (humidity_hysteresis_ff),
      .mode_next  (humidity_next)
   );

   chls_band u_temperature_band (
      .mode       (rsp_ff.temperature_command),
      .reading    (sample3_ff),
      .target     (target_temperature_ff),
      .hysteresis (temperature_hysteresis_ff),
      .mode_next  (temperature_next)
   );

   always_comb begin
      light_next = (minute >= light_on_minute_ff) && (minute < light_off_minute_ff);
      rsp_in     = rsp_ff;
      case (kind3_ff)
         chls_pkg::KIND_HUMIDITY: begin
            rsp_in.humidity_command = humidity_next;
         end
         chls_pkg::KIND_TEMPERATURE: begin
            rsp_in.temperature_command = temperature_next;
         end
         chls_pkg::KIND_CLOCK: begin
            rsp_in.light_command = light_next;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_humidity_ff        <= '0;
         humidity_hysteresis_ff    <= '0;
         target_temperature_ff     <= '0;
         temperature_hysteresis_ff <= '0;
         light_on_minute_ff        <= '0;
         light_off_minute_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            chls_pkg::CSR_TARGET_HUMIDITY: begin
               target_humidity_ff <= csr_data;
            end
            chls_pkg::CSR_HUMIDITY_HYSTERESIS: begin
               humidity_hysteresis_ff <= csr_data[14:0];
            end
            chls_pkg::CSR_TARGET_TEMPERATURE: begin
               target_temperature_ff <= csr_data;
            end
            chls_pkg::CSR_TEMPERATURE_HYSTERESIS: begin
               temperature_hysteresis_ff <= csr_data[14:0];
            end
            chls_pkg::CSR_LIGHT_ON_MINUTE: begin
               light_on_minute_ff <= csr_data[10:0];
            end
            chls_pkg::CSR_LIGHT_OFF_MINUTE: begin
               light_off_minute_ff <= csr_data[10:0];
            end
            default: begin
               light_off_minute_ff <= light_off_minute_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv4) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.en1) begin
         kind1_ff   <= req_data.kind;
         sample1_ff <= req_data.sample;
      end
      if (stage_en.en2) begin
         kind2_ff   <= kind1_ff;
         sample2_ff <= sample1_ff;
      end
      if (stage_en.en3) begin
         kind3_ff   <= kind2_ff;
         sample3_ff <= sample2_ff;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with a free stage");

   a_unknown_holds: assert property (@(posedge clock) disable iff (reset)
      (adv4 && kind3_ff == chls_pkg::KIND_UNKNOWN) |=> (rsp_ff == $past(rsp_ff)))
      else $error("unknown event changed a command");

   a_light_only_on_clock: assert property (@(posedge clock) disable iff (reset)
      (adv4 && kind3_ff != chls_pkg::KIND_CLOCK) |=> $stable(rsp_ff.light_command))
      else $error("light changed on a sensor event");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !v1_ff && !v2_ff && !v3_ff))
      else $error("pipeline not empty after reset");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int SECONDS_PER_MINUTE = 60;
   localparam int MINUTES_IN_DAY     = 1440;
   localparam int HOLD_CYCLES        = 64;
   localparam int WATCHDOG_LIMIT     = 2000;
   localparam int RANDOM_PHASES      = 6;
   localparam int BEATS_PER_PHASE    = 125;
   localparam int REPORT_LIMIT       = 10;

   localparam chls_pkg::csr_index_type CSR_UNMAPPED_LOW  = 3'd6;
   localparam chls_pkg::csr_index_type CSR_UNMAPPED_HIGH = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   chls_pkg::req_type       req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   chls_pkg::rsp_type       rsp_data;
   logic                    csr_valid;
   logic                    csr_ready;
   chls_pkg::csr_index_type csr_index;
   logic [15:0]             csr_data;

   climate_hysteresis_light_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // controller copy: setpoints, bands, light window and actuator modes
   logic signed [15:0] hum_target  = '0;
   logic [14:0]        hum_band    = '0;
   logic signed [15:0] temp_target = '0;
   logic [14:0]        temp_band   = '0;
   logic [10:0]        lamp_from   = '0;
   logic [10:0]        lamp_until  = '0;
   chls_pkg::cmd_type  hum_mode    = chls_pkg::CMD_OFF;
   chls_pkg::cmd_type  temp_mode   = chls_pkg::CMD_OFF;
   logic               lamp_on     = 1'b0;

   chls_pkg::rsp_type pending_cmds[$];

   typedef struct {
      bit                      reg_row;
      chls_pkg::csr_index_type idx;
      logic [15:0]             value;
      chls_pkg::req_type       beat;
      bit                      known;
      chls_pkg::rsp_type       want;
   } plan_row_type;

   plan_row_type plan[$];

   bit  send_idle    = 1'b1;
   bit  recv_idle    = 1'b1;
   bit  hold_request = 1'b0;
   int  beats_sent   = 0;
   int  results_seen = 0;
   int  reg_writes   = 0;
   int  settings     = 0;
   int  mismatches   = 0;
   int  quiet        = 0;
   int  kind_seen[4] = '{0, 0, 0, 0};
   chls_pkg::rsp_type head_cmd;

   function automatic chls_pkg::cmd_type band_command(input chls_pkg::cmd_type mode,
                                                      input logic signed [15:0] reading,
                                                      input logic signed [15:0] target,
                                                      input logic [14:0] band);
      int r, t, half, quarter;
      r       = reading;
      t       = target;
      half    = band >> 1;
      quarter = band >> 2;
      if (r > t + half)
         return chls_pkg::CMD_HIGH;
      if (r < t - half)
         return chls_pkg::CMD_LOW;
      if (r >= t - quarter && r <= t + quarter)
         return chls_pkg::CMD_OFF;
      return mode;
   endfunction

   function automatic chls_pkg::rsp_type climate_step(input chls_pkg::req_type b);
      int unsigned       secs;
      int unsigned       minute;
      chls_pkg::rsp_type cmds;
      case (b.kind)
         chls_pkg::KIND_HUMIDITY: begin
            hum_mode = band_command(hum_mode, b.sample, hum_target, hum_band);
         end
         chls_pkg::KIND_TEMPERATURE: begin
            temp_mode = band_command(temp_mode, b.sample, temp_target, temp_band);
         end
         chls_pkg::KIND_CLOCK: begin
            secs    = {1'b0, b.unix_seconds};
            minute  = (secs / SECONDS_PER_MINUTE) % MINUTES_IN_DAY;
            lamp_on = (minute >= lamp_from) && (minute < lamp_until);
         end
         default: ;
      endcase
      cmds.humidity_command    = hum_mode;
      cmds.temperature_command = temp_mode;
      cmds.light_command       = lamp_on;
      return cmds;
   endfunction

   function automatic void plan_reg(input chls_pkg::csr_index_type idx,
                                    input logic [15:0] value);
      plan_row_type r;
      r.reg_row = 1'b1;
      r.idx     = idx;
      r.value   = value;
      r.beat    = '0;
      r.known   = 1'b0;
      r.want    = '0;
      plan.push_back(r);
   endfunction

   function automatic void plan_known(input chls_pkg::kind_type k, input int s,
                                      input logic [30:0] secs, input bit known,
                                      input chls_pkg::cmd_type h, input chls_pkg::cmd_type t,
                                      input logic l);
      plan_row_type r;
      r.reg_row                  = 1'b0;
      r.idx                      = chls_pkg::CSR_TARGET_HUMIDITY;
      r.value                    = '0;
      r.beat.kind                = k;
      r.beat.sample              = s[15:0];
      r.beat.unix_seconds        = secs;
      r.known                    = known;
      r.want.humidity_command    = h;
      r.want.temperature_command = t;
      r.want.light_command       = l;
      plan.push_back(r);
   endfunction

   function automatic void plan_beat(input chls_pkg::kind_type k, input int s,
                                     input logic [30:0] secs);
      plan_known(k, s, secs, 1'b0, chls_pkg::CMD_OFF, chls_pkg::CMD_OFF, 1'b0);
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 48);
   endfunction

   function automatic logic [15:0] pick_word(input int lo, input int hi);
      logic [31:0] w;
      int          v;
      w = $urandom();
      if ($urandom_range(3) == 0)
         return w[15:0];
      v = lo + int'($urandom_range(0, hi - lo));
      return v[15:0];
   endfunction

   function automatic logic [15:0] near_setpoint(input logic signed [15:0] centre,
                                                 input logic [14:0] band);
      int span, c, v;
      span = (band >> 1) + 4;
      c    = centre;
      v    = c + int'($urandom_range(0, 2 * span)) - span;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v[15:0];
   endfunction

   function automatic chls_pkg::req_type random_beat();
      chls_pkg::req_type b;
      logic [31:0]       w;
      int                r, m;
      longint            secs;
      r              = $urandom_range(99);
      w              = $urandom();
      b.sample       = w[15:0];
      w              = $urandom();
      b.unix_seconds = w[30:0];
      if (r < 35) begin
         b.kind = chls_pkg::KIND_HUMIDITY;
         if (r >= 5)
            b.sample = near_setpoint(hum_target, hum_band);
      end else if (r < 70) begin
         b.kind = chls_pkg::KIND_TEMPERATURE;
         if (r >= 40)
            b.sample = near_setpoint(temp_target, temp_band);
      end else if (r < 92) begin
         b.kind = chls_pkg::KIND_CLOCK;
         if (r >= 78) begin
            // land on or beside a window edge
            m = ($urandom_range(1) != 0) ? int'(lamp_from) : int'(lamp_until);
            m = m + int'($urandom_range(0, 2)) - 1;
            if (m < 0 || m >= MINUTES_IN_DAY)
               m = $urandom_range(0, MINUTES_IN_DAY - 1);
            secs = longint'($urandom_range(0, 24854)) * 86400
                   + longint'(m) * SECONDS_PER_MINUTE + longint'($urandom_range(0, 59));
            b.unix_seconds = secs[30:0];
         end
      end else begin
         b.kind = chls_pkg::KIND_UNKNOWN;
      end
      return b;
   endfunction

   function automatic void report_mismatch(input string what, input chls_pkg::rsp_type want);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s result %0d: expected hum %0d temp %0d light %0d, got hum %0d temp %0d light %0d",
                  $realtime, what, results_seen, want.humidity_command,
                  want.temperature_command, want.light_command, rsp_data.humidity_command,
                  rsp_data.temperature_command, rsp_data.light_command);
   endfunction

   task automatic offer_reading(input chls_pkg::req_type b, input bit known,
                                input chls_pkg::rsp_type want);
      int                gap;
      chls_pkg::rsp_type cmds;
      gap = (send_idle && $urandom_range(1) != 0) ? idle_len() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      cmds = climate_step(b);
      pending_cmds.push_back(known ? want : cmds);
      beats_sent++;
      kind_seen[b.kind]++;
   endtask

   // drop valid, drain every expected beat, then let the pipeline go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input chls_pkg::csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         chls_pkg::CSR_TARGET_HUMIDITY:        hum_target  = value;
         chls_pkg::CSR_HUMIDITY_HYSTERESIS:    hum_band    = value[14:0];
         chls_pkg::CSR_TARGET_TEMPERATURE:     temp_target = value;
         chls_pkg::CSR_TEMPERATURE_HYSTERESIS: temp_band   = value[14:0];
         chls_pkg::CSR_LIGHT_ON_MINUTE:        lamp_from   = value[10:0];
         chls_pkg::CSR_LIGHT_OFF_MINUTE:       lamp_until  = value[10:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_phase(input int p);
      logic [31:0] w;
      settle();
      settings++;
      case (p)
         0: begin
            write_reg(chls_pkg::CSR_TARGET_HUMIDITY, 16'h7fff);
            write_reg(chls_pkg::CSR_HUMIDITY_HYSTERESIS, 16'h7fff);
            write_reg(chls_pkg::CSR_TARGET_TEMPERATURE, 16'h8000);
            write_reg(chls_pkg::CSR_TEMPERATURE_HYSTERESIS, 16'h0000);
            write_reg(chls_pkg::CSR_LIGHT_ON_MINUTE, 16'h0000);
            write_reg(chls_pkg::CSR_LIGHT_OFF_MINUTE, 16'hffff);
         end
         1: begin
            write_reg(chls_pkg::CSR_TARGET_HUMIDITY, 16'h8000);
            write_reg(chls_pkg::CSR_HUMIDITY_HYSTERESIS, 16'hffff);
            write_reg(chls_pkg::CSR_TARGET_TEMPERATURE, 16'h7fff);
            write_reg(chls_pkg::CSR_TEMPERATURE_HYSTERESIS, 16'h7fff);
            write_reg(chls_pkg::CSR_LIGHT_ON_MINUTE, 16'hffff);
            write_reg(chls_pkg::CSR_LIGHT_OFF_MINUTE, 16'h0000);
         end
         default: begin
            write_reg(chls_pkg::CSR_TARGET_HUMIDITY, pick_word(-300, 300));
            write_reg(chls_pkg::CSR_HUMIDITY_HYSTERESIS, pick_word(0, 400));
            write_reg(chls_pkg::CSR_TARGET_TEMPERATURE, pick_word(-300, 300));
            write_reg(chls_pkg::CSR_TEMPERATURE_HYSTERESIS, pick_word(0, 400));
            write_reg(chls_pkg::CSR_LIGHT_ON_MINUTE, pick_word(0, MINUTES_IN_DAY - 1));
            write_reg(chls_pkg::CSR_LIGHT_OFF_MINUTE, pick_word(0, MINUTES_IN_DAY - 1));
            w = $urandom();
            write_reg(($urandom_range(1) != 0) ? CSR_UNMAPPED_LOW : CSR_UNMAPPED_HIGH, w[15:0]);
         end
      endcase
   endtask

   initial begin
      int len;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (recv_idle && $urandom_range(99) < 25) begin
            len = idle_len();
            rsp_stall <= 1'b1;
            repeat (len) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_cmds.size() == 0) begin
            report_mismatch("unexpected", '0);
         end else begin
            head_cmd = pending_cmds.pop_front();
            if (rsp_data.humidity_command !== head_cmd.humidity_command
                || rsp_data.temperature_command !== head_cmd.temperature_command
                || rsp_data.light_command !== head_cmd.light_command)
               report_mismatch("wrong", head_cmd);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d beats still expected",
                  quiet, pending_cmds.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int p, i;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = chls_pkg::CSR_TARGET_HUMIDITY;
      csr_data  = '0;
      reset     = 1'b1;

      // reset settings: zero setpoints, zero bands, empty light window
      plan_known(chls_pkg::KIND_HUMIDITY, 0, 31'd0, 1'b1,
                 chls_pkg::CMD_OFF, chls_pkg::CMD_OFF, 1'b0);
      plan_known(chls_pkg::KIND_HUMIDITY, 32767, 31'h7fffffff, 1'b1,
                 chls_pkg::CMD_HIGH, chls_pkg::CMD_OFF, 1'b0);
      plan_known(chls_pkg::KIND_TEMPERATURE, -32768, 31'd0, 1'b1,
                 chls_pkg::CMD_HIGH, chls_pkg::CMD_LOW, 1'b0);
      plan_known(chls_pkg::KIND_UNKNOWN, -1, 31'h7fffffff, 1'b1,
                 chls_pkg::CMD_HIGH, chls_pkg::CMD_LOW, 1'b0);
      plan_known(chls_pkg::KIND_CLOCK, 32767, 31'd0, 1'b1,
                 chls_pkg::CMD_HIGH, chls_pkg::CMD_LOW, 1'b0);
      plan_known(chls_pkg::KIND_CLOCK, -32768, 31'h7fffffff, 1'b1,
                 chls_pkg::CMD_HIGH, chls_pkg::CMD_LOW, 1'b0);
      plan_known(chls_pkg::KIND_HUMIDITY, 0, 31'd0, 1'b1,
                 chls_pkg::CMD_OFF, chls_pkg::CMD_LOW, 1'b0);
      plan_known(chls_pkg::KIND_TEMPERATURE, 0, 31'd0, 1'b1,
                 chls_pkg::CMD_OFF, chls_pkg::CMD_OFF, 1'b0);
      // band edges, hold zones, dropped upper bits, unmapped indexes, window edges
      plan_reg(chls_pkg::CSR_TARGET_HUMIDITY, 16'd100);
      plan_reg(chls_pkg::CSR_HUMIDITY_HYSTERESIS, 16'h8028);
      plan_reg(chls_pkg::CSR_TARGET_TEMPERATURE, 16'h8000);
      plan_reg(chls_pkg::CSR_TEMPERATURE_HYSTERESIS, 16'hffff);
      plan_reg(chls_pkg::CSR_LIGHT_ON_MINUTE, 16'hf83c);
      plan_reg(chls_pkg::CSR_LIGHT_OFF_MINUTE, 16'd120);
      plan_reg(CSR_UNMAPPED_LOW, 16'hffff);
      plan_reg(CSR_UNMAPPED_HIGH, 16'h1234);
      plan_beat(chls_pkg::KIND_HUMIDITY, 121, 31'd5);
      plan_beat(chls_pkg::KIND_HUMIDITY, 120, 31'd5);
      plan_beat(chls_pkg::KIND_HUMIDITY, 110, 31'd5);
      plan_beat(chls_pkg::KIND_HUMIDITY, 90, 31'd5);
      plan_beat(chls_pkg::KIND_HUMIDITY, 89, 31'd5);
      plan_beat(chls_pkg::KIND_HUMIDITY, 79, 31'd5);
      plan_beat(chls_pkg::KIND_HUMIDITY, 80, 31'd5);
      plan_beat(chls_pkg::KIND_HUMIDITY, 111, 31'd5);
      plan_beat(chls_pkg::KIND_TEMPERATURE, 32767, 31'd0);
      plan_beat(chls_pkg::KIND_TEMPERATURE, -32768, 31'd0);
      plan_beat(chls_pkg::KIND_CLOCK, 0, 31'd3599);
      plan_beat(chls_pkg::KIND_CLOCK, 0, 31'd3600);
      plan_beat(chls_pkg::KIND_CLOCK, 0, 31'd7199);
      plan_beat(chls_pkg::KIND_CLOCK, 0, 31'd7200);
      plan_beat(chls_pkg::KIND_CLOCK, 0, 31'd90000);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settings = 2;

      foreach (plan[row]) begin
         if (plan[row].reg_row) begin
            settle();
            write_reg(plan[row].idx, plan[row].value);
         end else begin
            offer_reading(plan[row].beat, plan[row].known, plan[row].want);
         end
      end

      for (p = 0; p < RANDOM_PHASES; p++) begin
         program_phase(p);
         case (p)
            0: begin
               send_idle = 1'b1;
               recv_idle = 1'b1;
            end
            1: begin
               send_idle = 1'b0;
               recv_idle = 1'b0;
            end
            2: begin
               send_idle    = 1'b0;
               recv_idle    = 1'b1;
               hold_request = 1'b1;
            end
            default: begin
               send_idle = 1'($urandom_range(1));
               recv_idle = 1'($urandom_range(1));
            end
         endcase
         for (i = 0; i < BEATS_PER_PHASE; i++) begin
            if (i == BEATS_PER_PHASE / 2)
               settle();
            offer_reading(random_beat(), 1'b0, '0);
         end
      end

      settle();
      $display("covered %0d beats (%0d humidity, %0d temperature, %0d clock, %0d unknown)",
               beats_sent, kind_seen[chls_pkg::KIND_HUMIDITY],
               kind_seen[chls_pkg::KIND_TEMPERATURE],
               kind_seen[chls_pkg::KIND_CLOCK], kind_seen[chls_pkg::KIND_UNKNOWN]);
      $display("over %0d register settings with %0d writes; %0d results checked, %0d mismatches",
               settings, reg_writes, results_seen, mismatches);
      if (mismatches == 0 && pending_cmds.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
